@@ design/repeat_cycle_sequencer_top_assert.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef REPEAT_CYCLE_SEQUENCER_TOP_ASSERT_SVH
`define REPEAT_CYCLE_SEQUENCER_TOP_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define RCS_ASSERT_SAME(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// Condition c must hold in the cycle after a.
`define RCS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`endif

@@ design/rcs_pkg.sv @@
package rcs_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned FieldW    = 16;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_COND = 2'd1,
    PH_EXEC = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_PAUSE  = 2'd2,
    CMD_RESUME = 2'd3
  } cmd_e;

  // conditioning modes; any other code behaves as time only
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_TEMP = 2'd2;

  // register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] REG_COND_MODE   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_COND_LIMIT  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_TARGET_TEMP = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_TEMP_SENSOR = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_EXEC_LIMIT  = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_REPEAT_TOT  = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_SEC_CHECK   = 3'd6;

  typedef struct packed {
    logic [1:0]               cond_mode;
    logic [FieldW-1:0]        cond_limit;
    logic signed [FieldW-1:0] target_temp;
    logic                     temp_present;
    logic [FieldW-1:0]        exec_limit;
    logic [FieldW-1:0]        repeat_total;
    logic                     sec_enable;
  } cfg_t;

  // result item; member order matches tdata from the high bits down
  typedef struct packed {
    logic              run_ok;
    logic              run_finished;
    logic              security_violation;
    logic              repeat_ok;
    logic              repeat_finished;
    logic              condition_done;
    logic [FieldW-1:0] failed_repeats;
    logic [FieldW-1:0] good_repeats;
    logic [FieldW-1:0] elapsed_ticks;
    logic [FieldW-1:0] repeat_index;
    logic              paused_flag;
    logic [1:0]        phase;
  } result_t;

endpackage

@@ design/rcs_cfg_regs.sv @@
module rcs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [rcs_pkg::CfgAddrW-1:0]        addr_i,
  input  logic [rcs_pkg::CfgWidth-1:0]        wdata_i,
  output rcs_pkg::cfg_t                       cfg_o
);

  rcs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (we_i) begin
      unique case (addr_i)
        rcs_pkg::REG_COND_MODE:   cfg_q.cond_mode    <= wdata_i[1:0];
        rcs_pkg::REG_COND_LIMIT:  cfg_q.cond_limit   <= wdata_i;
        rcs_pkg::REG_TARGET_TEMP: cfg_q.target_temp  <= $signed(wdata_i);
        rcs_pkg::REG_TEMP_SENSOR: cfg_q.temp_present <= wdata_i[0];
        rcs_pkg::REG_EXEC_LIMIT:  cfg_q.exec_limit   <= wdata_i;
        rcs_pkg::REG_REPEAT_TOT:  cfg_q.repeat_total <= wdata_i;
        rcs_pkg::REG_SEC_CHECK:   cfg_q.sec_enable   <= wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/rcs_core.sv @@
module rcs_core #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  rcs_pkg::cmd_e                     cmd_i,
  input  logic signed [rcs_pkg::FieldW-1:0] temp_i,
  input  logic                              pressure_ok_i,
  input  rcs_pkg::cfg_t                     cfg_i,
  output rcs_pkg::result_t                  res_o
);

  localparam int unsigned TCmpW = (TIME_WIDTH  > rcs_pkg::FieldW) ? TIME_WIDTH  : rcs_pkg::FieldW;
  localparam int unsigned CCmpW = (COUNT_WIDTH > rcs_pkg::FieldW) ? COUNT_WIDTH : rcs_pkg::FieldW;

  rcs_pkg::phase_e         phase_q, phase_d;
  logic                    paused_q, paused_d;
  logic [TIME_WIDTH-1:0]   elapsed_q, elapsed_d;
  logic [COUNT_WIDTH-1:0]  rep_q, rep_d;
  logic [COUNT_WIDTH-1:0]  good_q, good_d;
  logic [COUNT_WIDTH-1:0]  fail_q, fail_d;

  logic cond_done, rep_fin, rep_ok, sec_viol, run_fin, run_ok;
  logic go_next, met, stop;
  logic [TCmpW-1:0] el_ext;
  logic [CCmpW-1:0] rep_ext, good_ext, fail_ext;

  // saturated elapsed time counts as having reached any limit
  function automatic logic reached(logic [TIME_WIDTH-1:0] el, logic [rcs_pkg::FieldW-1:0] lim);
    logic [TCmpW-1:0] a;
    logic [TCmpW-1:0] b;
    a = TCmpW'(el);
    b = TCmpW'(lim);
    return (a >= b) || (&el);
  endfunction

  always_comb begin
    phase_d   = phase_q;
    paused_d  = paused_q;
    elapsed_d = elapsed_q;
    rep_d     = rep_q;
    good_d    = good_q;
    fail_d    = fail_q;
    cond_done = 1'b0;
    rep_fin   = 1'b0;
    rep_ok    = 1'b0;
    sec_viol  = 1'b0;
    run_fin   = 1'b0;
    run_ok    = 1'b0;
    go_next   = 1'b0;
    met       = 1'b0;
    stop      = 1'b0;

    unique case (cmd_i)
      rcs_pkg::CMD_START: begin
        rep_d    = '0;
        good_d   = '0;
        fail_d   = '0;
        paused_d = 1'b0;
        go_next  = 1'b1;
      end
      rcs_pkg::CMD_TICK: begin
        if (!paused_q && phase_q != rcs_pkg::PH_IDLE) begin
          elapsed_d = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
          if (phase_q == rcs_pkg::PH_COND) begin
            met = reached(elapsed_d, cfg_i.cond_limit);
            if (cfg_i.cond_mode == rcs_pkg::MODE_TEMP && cfg_i.temp_present &&
                temp_i <= cfg_i.target_temp) begin
              met = 1'b1;
            end
            if (met) begin
              cond_done = 1'b1;
              phase_d   = rcs_pkg::PH_EXEC;
              elapsed_d = '0;
            end
          end else begin
            sec_viol = cfg_i.sec_enable && !pressure_ok_i;
            if (sec_viol || reached(elapsed_d, cfg_i.exec_limit)) begin
              rep_fin = 1'b1;
              rep_ok  = !sec_viol;
              if (sec_viol) begin
                fail_d = (&fail_q) ? fail_q : fail_q + 1'b1;
              end else begin
                good_d = (&good_q) ? good_q : good_q + 1'b1;
              end
              rep_d   = (&rep_q) ? rep_q : rep_q + 1'b1;
              go_next = 1'b1;
            end
          end
        end
      end
      rcs_pkg::CMD_PAUSE: begin
        if (phase_q != rcs_pkg::PH_IDLE) begin
          paused_d = 1'b1;
        end
      end
      rcs_pkg::CMD_RESUME: begin
        paused_d = 1'b0;
      end
      default: ;
    endcase

    // move on to the next repeat, or close the run
    if (go_next) begin
      elapsed_d = '0;
      stop = (CCmpW'(rep_d) >= CCmpW'(cfg_i.repeat_total)) || (&rep_d);
      if (stop) begin
        phase_d = rcs_pkg::PH_IDLE;
        run_fin = 1'b1;
        run_ok  = (fail_d == '0);
      end else if (cfg_i.cond_mode == rcs_pkg::MODE_NONE || cfg_i.cond_limit == '0) begin
        phase_d = rcs_pkg::PH_EXEC;
      end else begin
        phase_d = rcs_pkg::PH_COND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rcs_pkg::PH_IDLE;
      paused_q  <= 1'b0;
      elapsed_q <= '0;
      rep_q     <= '0;
      good_q    <= '0;
      fail_q    <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      paused_q  <= paused_d;
      elapsed_q <= elapsed_d;
      rep_q     <= rep_d;
      good_q    <= good_d;
      fail_q    <= fail_d;
    end
  end

  assign el_ext   = TCmpW'(elapsed_d);
  assign rep_ext  = CCmpW'(rep_d);
  assign good_ext = CCmpW'(good_d);
  assign fail_ext = CCmpW'(fail_d);

  always_comb begin
    res_o.phase              = phase_d;
    res_o.paused_flag        = paused_d;
    res_o.repeat_index       = rep_ext[rcs_pkg::FieldW-1:0];
    res_o.elapsed_ticks      = el_ext[rcs_pkg::FieldW-1:0];
    res_o.good_repeats       = good_ext[rcs_pkg::FieldW-1:0];
    res_o.failed_repeats     = fail_ext[rcs_pkg::FieldW-1:0];
    res_o.condition_done     = cond_done;
    res_o.repeat_finished    = rep_fin;
    res_o.repeat_ok          = rep_ok;
    res_o.security_violation = sec_viol;
    res_o.run_finished       = run_fin;
    res_o.run_ok             = run_ok;
  end

endmodule

@@ design/rcs_out_reg.sv @@
module rcs_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rcs_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             free_o,
  output logic             valid_o,
  output rcs_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  rcs_pkg::result_t res_q;

  // slot is free when empty or being drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ design/repeat_cycle_sequencer_top.sv @@
// A result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle; the single output register is reloaded in the
// cycle it drains, so the input stalls only while a result waits downstream.
// Reset (rst_ni, async, active low): configuration registers, phase, pause flag
// and all counters clear to zero; no result is pending.
module repeat_cycle_sequencer_top #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcs_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rcs_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] temperature_sample, [16] pressure_ok, [23:17] zero
  input  logic [23:0]                  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] phase, [2] paused_flag, [18:3] repeat_index, [34:19] elapsed_ticks,
  // [50:35] good_repeats, [66:51] failed_repeats, [67] condition_done,
  // [68] repeat_finished, [69] repeat_ok, [70] security_violation,
  // [71] run_finished, [72] run_ok, [79:73] zero
  output logic [79:0]                  m_axis_tdata
);

  localparam int unsigned ResW = $bits(rcs_pkg::result_t);

  rcs_pkg::cfg_t    cfg;
  rcs_pkg::result_t res_next, res_out;
  rcs_pkg::cmd_e    cmd;
  logic             in_fire;
  logic             slot_free;

  assign cmd     = rcs_pkg::cmd_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = slot_free;

  rcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  rcs_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .cmd_i         (cmd),
    .temp_i        ($signed(s_axis_tdata[15:0])),
    .pressure_ok_i (s_axis_tdata[16]),
    .cfg_i         (cfg),
    .res_o         (res_next)
  );

  rcs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .res_i   (res_next),
    .ready_i (m_axis_tready),
    .free_o  (slot_free),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {{(80 - ResW){1'b0}}, res_out};

`include "repeat_cycle_sequencer_top_assert.svh"

  `RCS_ASSERT_SAME(a_run_end_idle, clk_i, rst_ni, m_axis_tvalid && res_out.run_finished, res_out.phase == rcs_pkg::PH_IDLE && !res_out.paused_flag, "run finished but sequencer not idle")
  `RCS_ASSERT_SAME(a_ok_needs_fin, clk_i, rst_ni, m_axis_tvalid && (res_out.repeat_ok || res_out.security_violation), res_out.repeat_finished, "repeat status without repeat end")
  `RCS_ASSERT_SAME(a_sec_is_fail, clk_i, rst_ni, m_axis_tvalid && res_out.security_violation, !res_out.repeat_ok && res_out.condition_done == 1'b0, "pressure abort reported as success")
  `RCS_ASSERT_NEXT(a_fire_gives_out, clk_i, rst_ni, in_fire, m_axis_tvalid, "accepted item produced no result")

endmodule

@@ verif/testbench.sv @@
module testbench;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 80;

  // Predicts the sequencer status for every accepted command and checks returned status.
  class seq_scoreboard;
    rcs_pkg::cfg_t    settings;
    rcs_pkg::phase_e  phase;
    logic             paused;
    logic [15:0]      elapsed;
    logic [15:0]      repeats_done;
    logic [15:0]      good_cnt;
    logic [15:0]      failed_cnt;
    rcs_pkg::result_t nxt;
    rcs_pkg::result_t status_q[$];
    int unsigned      errors;

    function new();
      settings     = '0;
      phase        = rcs_pkg::PH_IDLE;
      paused       = 1'b0;
      elapsed      = '0;
      repeats_done = '0;
      good_cnt     = '0;
      failed_cnt   = '0;
      errors       = 0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // a saturated tick count counts as reaching any limit
    function logic limit_hit(logic [15:0] lim);
      return (elapsed >= lim) || (elapsed == 16'hFFFF);
    endfunction

    function void advance_repeat();
      elapsed = '0;
      if (repeats_done >= settings.repeat_total || repeats_done == 16'hFFFF) begin
        phase            = rcs_pkg::PH_IDLE;
        nxt.run_finished = 1'b1;
        nxt.run_ok       = (failed_cnt == 0);
      end else if (settings.cond_mode == rcs_pkg::MODE_NONE || settings.cond_limit == 0) begin
        phase = rcs_pkg::PH_EXEC;
      end else begin
        phase = rcs_pkg::PH_COND;
      end
    endfunction

    function void close_repeat(logic ok);
      if (ok) good_cnt = bump(good_cnt);
      else failed_cnt = bump(failed_cnt);
      nxt.repeat_finished = 1'b1;
      nxt.repeat_ok       = ok;
      repeats_done        = bump(repeats_done);
      advance_repeat();
    endfunction

    function void note_command(rcs_pkg::cmd_e cmd, logic signed [15:0] temp, logic pok);
      logic met;
      nxt = '0;
      case (cmd)
        rcs_pkg::CMD_START: begin
          repeats_done = '0;
          good_cnt     = '0;
          failed_cnt   = '0;
          paused       = 1'b0;
          advance_repeat();
        end
        rcs_pkg::CMD_TICK: begin
          if (!paused && phase != rcs_pkg::PH_IDLE) begin
            elapsed = bump(elapsed);
            if (phase == rcs_pkg::PH_COND) begin
              met = limit_hit(settings.cond_limit);
              if (settings.cond_mode == rcs_pkg::MODE_TEMP && settings.temp_present &&
                  $signed(temp) <= $signed(settings.target_temp)) met = 1'b1;
              if (met) begin
                nxt.condition_done = 1'b1;
                phase              = rcs_pkg::PH_EXEC;
                elapsed            = '0;
              end
            end else if (settings.sec_enable && !pok) begin
              nxt.security_violation = 1'b1;
              close_repeat(1'b0);
            end else if (limit_hit(settings.exec_limit)) begin
              close_repeat(1'b1);
            end
          end
        end
        rcs_pkg::CMD_PAUSE: begin
          if (!paused && phase != rcs_pkg::PH_IDLE) paused = 1'b1;
        end
        default: begin
          paused = 1'b0;
        end
      endcase
      nxt.phase          = phase;
      nxt.paused_flag    = paused;
      nxt.repeat_index   = repeats_done;
      nxt.elapsed_ticks  = elapsed;
      nxt.good_repeats   = good_cnt;
      nxt.failed_repeats = failed_cnt;
      status_q.push_back(nxt);
    endfunction

    function void cmp_field(string nm, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, nm, want_v, got_v);
      end
    endfunction

    function void check_status(rcs_pkg::result_t got);
      rcs_pkg::result_t want;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: status with nothing expected, expected none actual %h", $time, got);
        return;
      end
      want = status_q.pop_front();
      cmp_field("phase", want.phase, got.phase);
      cmp_field("paused_flag", want.paused_flag, got.paused_flag);
      cmp_field("repeat_index", want.repeat_index, got.repeat_index);
      cmp_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
      cmp_field("good_repeats", want.good_repeats, got.good_repeats);
      cmp_field("failed_repeats", want.failed_repeats, got.failed_repeats);
      cmp_field("condition_done", want.condition_done, got.condition_done);
      cmp_field("repeat_finished", want.repeat_finished, got.repeat_finished);
      cmp_field("repeat_ok", want.repeat_ok, got.repeat_ok);
      cmp_field("security_violation", want.security_violation, got.security_violation);
      cmp_field("run_finished", want.run_finished, got.run_finished);
      cmp_field("run_ok", want.run_ok, got.run_ok);
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [rcs_pkg::CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [rcs_pkg::CfgWidth-1:0] cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata  = '0;
  logic [1:0]                   s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [79:0]                  m_axis_tdata;

  seq_scoreboard sb = new();
  bit            idling_on;
  bit            hold_off_req;
  int unsigned   cycle_count;

  repeat_cycle_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // handshake values are stable at the falling edge and hold until the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_status(m_axis_tdata[$bits(rcs_pkg::result_t)-1:0]);
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_cmd(rcs_pkg::cmd_e cmd, logic signed [15:0] temp, logic pok);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, pok, temp};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_command(cmd, temp, pok);
  endtask

  task automatic write_reg(logic [rcs_pkg::CfgAddrW-1:0] addr,
                           logic [rcs_pkg::CfgWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // only with no status outstanding
  task automatic apply_settings(rcs_pkg::cfg_t c);
    s_axis_tvalid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_reg(rcs_pkg::REG_COND_MODE, 16'(c.cond_mode));
    write_reg(rcs_pkg::REG_COND_LIMIT, c.cond_limit);
    write_reg(rcs_pkg::REG_TARGET_TEMP, c.target_temp);
    write_reg(rcs_pkg::REG_TEMP_SENSOR, 16'(c.temp_present));
    write_reg(rcs_pkg::REG_EXEC_LIMIT, c.exec_limit);
    write_reg(rcs_pkg::REG_REPEAT_TOT, c.repeat_total);
    write_reg(rcs_pkg::REG_SEC_CHECK, 16'(c.sec_enable));
    cfg_we_i <= 1'b0;
    sb.settings = c;
  endtask

  function automatic logic [15:0] pick_limit();
    return ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
  endfunction

  function automatic rcs_pkg::cfg_t random_settings();
    rcs_pkg::cfg_t c;
    c.cond_mode    = 2'($urandom_range(0, 3));
    c.cond_limit   = pick_limit();
    c.target_temp  = 16'($urandom);
    c.temp_present = 1'($urandom_range(0, 1));
    c.exec_limit   = pick_limit();
    c.repeat_total = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
    c.sec_enable   = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // mostly ticks; temperatures cluster around the target half the time
  task automatic random_item();
    int unsigned        pick;
    rcs_pkg::cmd_e      cmd;
    logic signed [15:0] temp;
    logic               pok;
    pick = $urandom_range(0, 99);
    if (pick < 4) cmd = rcs_pkg::CMD_START;
    else if (pick < 83) cmd = rcs_pkg::CMD_TICK;
    else if (pick < 88) cmd = rcs_pkg::CMD_PAUSE;
    else cmd = rcs_pkg::CMD_RESUME;
    if ($urandom_range(0, 1) == 0) temp = 16'($urandom);
    else temp = sb.settings.target_temp + 16'd4 - 16'($urandom_range(0, 8));
    pok = ($urandom_range(0, 9) != 0);
    send_cmd(cmd, temp, pok);
  endtask

  initial begin
    rcs_pkg::cfg_t c;
    int            p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling_on = 1'b1;

    // reset settings: zero repeats finish at once, idle commands do nothing
    send_cmd(rcs_pkg::CMD_START, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, -16'sd1, 1'b0);
    send_cmd(rcs_pkg::CMD_PAUSE, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_RESUME, 16'sd0, 1'b1);

    c              = '0;
    c.cond_mode    = rcs_pkg::MODE_TEMP;
    c.cond_limit   = 16'd3;
    c.temp_present = 1'b1;
    c.repeat_total = 16'd3;
    c.sec_enable   = 1'b1;
    apply_settings(c);
    send_cmd(rcs_pkg::CMD_START, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sh7FFF, 1'b1);
    send_cmd(rcs_pkg::CMD_PAUSE, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_PAUSE, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sh8000, 1'b1);
    send_cmd(rcs_pkg::CMD_RESUME, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_RESUME, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sh8000, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sd0, 1'b0);
    repeat (3) send_cmd(rcs_pkg::CMD_TICK, 16'sh7FFF, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_PAUSE, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_START, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_TICK, 16'sd5, 1'b1);
    send_cmd(rcs_pkg::CMD_START, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_PAUSE, 16'sd0, 1'b1);
    send_cmd(rcs_pkg::CMD_START, 16'sd0, 1'b1);

    // the last pass runs without idling
    for (p = 0; p < 12; p++) begin
      if (p == 0) begin
        c             = '1;
        c.target_temp = 16'sh7FFF;
      end else if (p == 1) begin
        c             = '0;
        c.target_temp = 16'sh8000;
      end else begin
        c = random_settings();
      end
      apply_settings(c);
      idling_on = (p % 3 != 2);
      if (p == 4) hold_off_req = 1'b1;
      send_cmd(rcs_pkg::CMD_START, 16'($urandom), 1'b1);
      repeat (150) random_item();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
